FILE: hw/rtl/vdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdec_pkg
// Shared types and codes for the varint field decoder.
// ----------------------------------------------------------------------------
package vdec_pkg;

    // field types
    localparam logic [2:0] FT_BYTE    = 3'd0;
    localparam logic [2:0] FT_SHORT   = 3'd1;
    localparam logic [2:0] FT_INT     = 3'd2;
    localparam logic [2:0] FT_LONG    = 3'd3;
    localparam logic [2:0] FT_VARINT  = 3'd4;
    localparam logic [2:0] FT_VARLONG = 3'd5;
    localparam logic [2:0] FT_STRING  = 3'd6;
    localparam logic [2:0] FT_RAW     = 3'd7;

    // beat kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERLONG = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    // config register indexes
    localparam logic CFG_VARINT_MAX  = 1'b0;
    localparam logic CFG_VARLONG_MAX = 1'b1;

    localparam logic [3:0] VARINT_MAX_RST  = 4'd5;
    localparam logic [3:0] VARLONG_MAX_RST = 4'd10;

    // LEB128 byte layout
    localparam logic [7:0] GROUP_MASK = 8'b0111_1111;
    localparam int         MORE_BIT   = 7;

    typedef struct packed {
        logic       kind;
        logic [2:0] field_type;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  result_type;
        logic [1:0]  status;
        logic        is_payload;
        logic        last_of_field;
        logic [31:0] bytes_consumed;
    } res_t;

endpackage

FILE: hw/rtl/field_deserializer_varint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_deserializer_varint
// Byte-stream protocol field decoder (fixed, LEB128 varint/varlong, string).
// ----------------------------------------------------------------------------
// One input beat carries one buffer byte (or an end-of-buffer mark) and yields
// at most one result beat. Each beat passes input register -> decode logic ->
// result register, so the block takes a new beat every cycle and a result
// is registered as its byte leaves the input register; only output backpressure
// slows it. A data byte seen while idle starts a field of the type given in
// s_tuser. Fixed-width fields are big-endian; varint/varlong use LEB128 and
// are limited to the byte counts in the config registers (exceeding the
// limit gives an overlong status on that byte). Strings emit their length,
// then each payload byte with is_payload set; tlast marks the final beat of
// every field and every error/done beat. End of buffer while idle reports
// the byte count (done); in mid-field it reports truncated. Config writes
// must only be made while the decoder is idle.
// ----------------------------------------------------------------------------
module field_deserializer_varint #(
    parameter int LENGTH_BITS = 32   // string length width, 8..32
) (
    input  logic        clk,
    input  logic        rst_n,

    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic [3:0]  s_tuser,     // [0] kind, [3:1] field_type

    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,     // [63:0] value, [95:64] bytes_consumed
    output logic [5:0]  m_tuser,     // [2:0] result_type, [4:3] status, [5] is_payload
    output logic        m_tlast,     // last_of_field

    // config writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    logic            in_valid_reg;
    vdec_pkg::item_t in_item_reg;
    logic            out_valid_reg;
    vdec_pkg::res_t  out_res_reg;
    logic [3:0]      varint_max_reg;
    logic [3:0]      varlong_max_reg;

    logic            advance;
    logic            core_valid;
    vdec_pkg::res_t  core_res;

    // input stage moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.kind       <= s_tuser[0];
            in_item_reg.field_type <= s_tuser[3:1];
            in_item_reg.data_byte  <= s_tdata;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            varint_max_reg  <= vdec_pkg::VARINT_MAX_RST;
            varlong_max_reg <= vdec_pkg::VARLONG_MAX_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == vdec_pkg::CFG_VARINT_MAX)
            begin
                varint_max_reg <= cfg_data;
            end
            if (cfg_index == vdec_pkg::CFG_VARLONG_MAX)
            begin
                varlong_max_reg <= cfg_data;
            end
        end
    end

    vdec_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (in_item_reg),
        .varint_max  (varint_max_reg),
        .varlong_max (varlong_max_reg),
        .res_valid   (core_valid),
        .res         (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= core_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.bytes_consumed, out_res_reg.value};
    assign m_tuser  = {out_res_reg.is_payload, out_res_reg.status, out_res_reg.result_type};
    assign m_tlast  = out_res_reg.last_of_field;

endmodule

FILE: hw/rtl/vdec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdec_core
// Decoder state and the single-pass next-state / result logic for one beat.
// ----------------------------------------------------------------------------
module vdec_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  vdec_pkg::item_t     item,
    input  logic [3:0]          varint_max,
    input  logic [3:0]          varlong_max,
    output logic                res_valid,
    output vdec_pkg::res_t      res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIXED,
        PH_VAR,
        PH_STRLEN,
        PH_PAYLOAD
    } phase_t;

    phase_t                   phase_reg,    phase_next;
    logic [2:0]               type_reg,     type_next;
    logic [3:0]               idx_reg,      idx_next;
    logic [63:0]              acc_reg,      acc_next;
    logic [LENGTH_BITS-1:0]   left_reg,     left_next;
    logic [31:0]              cons_reg,     cons_next;

    // varint path operands: fresh field when idle, running field otherwise
    logic [3:0]               v_idx;
    logic [63:0]              v_acc;
    logic [2:0]               v_type;
    logic                     v_wide;
    logic [3:0]               v_limit;
    logic                     v_over;
    logic [6:0]               v_shift;
    logic [63:0]              v_grp;
    logic [63:0]              v_acc_new;
    logic [LENGTH_BITS-1:0]   v_len;
    logic [3:0]               fix_need;
    logic [3:0]               idx_inc;
    logic [31:0]              cons_inc;
    logic [LENGTH_BITS-1:0]   left_dec;
    logic [7:0]               b;

    always_comb
    begin
        b         = item.data_byte;
        v_idx     = (phase_reg == PH_IDLE) ? 4'd0 : idx_reg;
        v_acc     = (phase_reg == PH_IDLE) ? 64'd0 : acc_reg;
        v_type    = (phase_reg == PH_IDLE) ? item.field_type : type_reg;
        v_wide    = (v_type == vdec_pkg::FT_VARLONG);
        v_limit   = v_wide ? varlong_max : varint_max;
        v_over    = ({1'b0, v_idx} + 5'd1) > {1'b0, v_limit};
        v_shift   = 7'(v_idx) * 7'd7;
        v_grp     = {56'd0, b & vdec_pkg::GROUP_MASK} << v_shift;
        if (!v_wide)
        begin
            v_grp = {32'd0, v_grp[31:0]};
        end
        v_acc_new = v_acc | v_grp;
        v_len     = v_acc_new[LENGTH_BITS-1:0];
        fix_need  = (type_reg == vdec_pkg::FT_SHORT) ? 4'd2 :
                    (type_reg == vdec_pkg::FT_INT)   ? 4'd4 : 4'd8;
        idx_inc   = idx_reg + 4'd1;
        cons_inc  = cons_reg + 32'd1;
        left_dec  = left_reg - LENGTH_BITS'(1);
    end

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        cons_next  = cons_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (item.kind == vdec_pkg::KIND_END)
        begin
            res_valid          = 1'b1;
            res.status         = (phase_reg == PH_IDLE) ? vdec_pkg::ST_DONE
                                                        : vdec_pkg::ST_TRUNC;
            res.result_type    = (phase_reg == PH_IDLE) ? 3'd0 : type_reg;
            res.last_of_field  = 1'b1;
            res.bytes_consumed = cons_reg;
            phase_next = PH_IDLE;
            idx_next   = 4'd0;
            acc_next   = 64'd0;
            left_next  = '0;
            cons_next  = 32'd0;
        end
        else
        begin
            cons_next          = cons_inc;
            res.bytes_consumed = cons_inc;
            res.status         = vdec_pkg::ST_OK;
            case (phase_reg)
                PH_IDLE, PH_VAR, PH_STRLEN:
                begin
                    type_next = v_type;
                    if (phase_reg == PH_IDLE &&
                        (item.field_type == vdec_pkg::FT_BYTE ||
                         item.field_type == vdec_pkg::FT_RAW))
                    begin
                        res_valid         = 1'b1;
                        res.value         = {56'd0, b};
                        res.result_type   = item.field_type;
                        res.last_of_field = 1'b1;
                        idx_next          = 4'd0;
                        acc_next          = 64'd0;
                    end
                    else if (phase_reg == PH_IDLE &&
                             item.field_type <= vdec_pkg::FT_LONG)
                    begin
                        phase_next = PH_FIXED;
                        acc_next   = {56'd0, b};
                        idx_next   = 4'd1;
                    end
                    else if (v_over)
                    begin
                        res_valid         = 1'b1;
                        res.result_type   = v_type;
                        res.status        = vdec_pkg::ST_OVERLONG;
                        res.last_of_field = 1'b1;
                        phase_next = PH_IDLE;
                        idx_next   = 4'd0;
                        acc_next   = 64'd0;
                        left_next  = '0;
                    end
                    else if (b[vdec_pkg::MORE_BIT])
                    begin
                        phase_next = (v_type == vdec_pkg::FT_STRING) ? PH_STRLEN : PH_VAR;
                        acc_next   = v_acc_new;
                        idx_next   = v_idx + 4'd1;
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res.result_type = v_type;
                        phase_next = PH_IDLE;
                        idx_next   = 4'd0;
                        acc_next   = 64'd0;
                        left_next  = '0;
                        if (v_type == vdec_pkg::FT_STRING)
                        begin
                            res.value = {{(64-LENGTH_BITS){1'b0}}, v_len};
                            if (v_len == '0)
                            begin
                                res.last_of_field = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                                left_next  = v_len;
                            end
                        end
                        else
                        begin
                            res.last_of_field = 1'b1;
                            res.value = v_wide ? v_acc_new
                                               : {{32{v_acc_new[31]}}, v_acc_new[31:0]};
                        end
                    end
                end
                PH_FIXED:
                begin
                    acc_next = {acc_reg[55:0], b};
                    idx_next = idx_inc;
                    if (idx_inc >= fix_need)
                    begin
                        res_valid         = 1'b1;
                        res.value         = {acc_reg[55:0], b};
                        res.result_type   = type_reg;
                        res.last_of_field = 1'b1;
                        phase_next = PH_IDLE;
                        idx_next   = 4'd0;
                        acc_next   = 64'd0;
                        left_next  = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid       = 1'b1;
                    res.value       = {56'd0, b};
                    res.result_type = vdec_pkg::FT_STRING;
                    res.is_payload  = 1'b1;
                    left_next       = left_dec;
                    if (left_dec == '0)
                    begin
                        res.last_of_field = 1'b1;
                        phase_next = PH_IDLE;
                        idx_next   = 4'd0;
                        acc_next   = 64'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            type_reg  <= 3'd0;
            idx_reg   <= 4'd0;
            acc_reg   <= 64'd0;
            left_reg  <= '0;
            cons_reg  <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            cons_reg  <= cons_next;
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the varint field decoder.
// ----------------------------------------------------------------------------
// A short directed run covers every field type, type seven, the varint limit,
// sign extension and width drop, empty and one-byte strings, and end of buffer
// while idle and in mid-field. Randomized phases follow, each under its own pair
// of length limits (extremes included). Most traffic is well-formed fields with
// random content. The rest is noise, bare end beats, overlong and cut-short fields.
// A scoreboard object carries its own copy of the decoder state. It predicts
// each result beat when the input beat is accepted, and compares every output
// beat field by field with the oldest prediction. Both ports stall at random.
// Once, the result side holds off for a long stretch so that the decoder backs
// up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LEN_BITS     = 32;   // matches the decoder default
    localparam int HOLD_CYCLES  = 150;  // long result-side stall
    localparam int DRAIN_CYCLES = 8;    // pipeline is two deep; margin on top

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_FIXED,
        DEC_VAR,
        DEC_LEN,
        DEC_PAYLOAD
    } dec_phase_t;

    // ------------------------------------------------------------------------
    // Scoreboard: decoder model plus the queue of predicted result beats
    // ------------------------------------------------------------------------
    class field_scoreboard;
        int              errors;
        int              n_checked;
        vdec_pkg::res_t  expected_q[$];
        dec_phase_t      ph;
        logic [2:0]      cur_type;
        int              nbytes;
        logic [63:0]     acc;
        logic [31:0]     str_left;
        logic [31:0]     count;
        logic [3:0]      varint_lim;
        logic [3:0]      varlong_lim;

        function new();
            errors      = 0;
            n_checked   = 0;
            varint_lim  = vdec_pkg::VARINT_MAX_RST;
            varlong_lim = vdec_pkg::VARLONG_MAX_RST;
            cur_type    = vdec_pkg::FT_BYTE;
            count       = '0;
            clear_field();
        endfunction

        function void clear_field();
            ph       = DEC_IDLE;
            nbytes   = 0;
            acc      = '0;
            str_left = '0;
        endfunction

        function void set_limit(logic idx, logic [3:0] val);
            if (idx == vdec_pkg::CFG_VARINT_MAX)
                varint_lim = val;
            else
                varlong_lim = val;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one LEB128 byte of a varint, varlong or string length
        function bit leb_byte(logic [7:0] b, inout vdec_pkg::res_t r);
            logic [63:0] grp;
            logic [63:0] v;
            bit          wide;
            int          lim;
            int          shift;
            wide = (cur_type == vdec_pkg::FT_VARLONG);
            lim  = wide ? int'(varlong_lim) : int'(varint_lim);
            shift = 7 * nbytes;
            r.result_type   = cur_type;
            r.last_of_field = 1'b1;
            // over the limit: rejected whatever its continuation bit says
            if (nbytes + 1 > lim) begin
                r.status = vdec_pkg::ST_OVERLONG;
                clear_field();
                return 1'b1;
            end
            grp = {56'd0, b & vdec_pkg::GROUP_MASK};
            if (wide) begin
                if (shift < 64)
                    acc |= grp << shift;
            end else if (shift < 32) begin
                acc |= (grp << shift) & 64'hFFFF_FFFF;
            end
            nbytes++;
            if (b[vdec_pkg::MORE_BIT])
                return 1'b0;
            if (cur_type == vdec_pkg::FT_STRING) begin
                v = acc & ((64'd1 << LEN_BITS) - 64'd1);
                clear_field();
                r.value = v;
                // a nonzero length opens the payload; the field is not over yet
                if (v != 64'd0) begin
                    ph              = DEC_PAYLOAD;
                    str_left        = v[31:0];
                    r.last_of_field = 1'b0;
                end
                return 1'b1;
            end
            v = wide ? acc : {{32{acc[31]}}, acc[31:0]};
            clear_field();
            r.value = v;
            return 1'b1;
        endfunction

        // returns 1 when the beat produces a result beat
        function bit decode_beat(vdec_pkg::item_t it, output vdec_pkg::res_t r);
            int need;
            r = '0;
            if (it.kind == vdec_pkg::KIND_END) begin
                r.status        = (ph == DEC_IDLE) ? vdec_pkg::ST_DONE : vdec_pkg::ST_TRUNC;
                r.result_type   = (ph == DEC_IDLE) ? vdec_pkg::FT_BYTE : cur_type;
                r.last_of_field = 1'b1;
                r.bytes_consumed = count;
                clear_field();
                count = '0;
                return 1'b1;
            end
            count++;
            r.bytes_consumed = count;
            case (ph)
                DEC_IDLE: begin
                    cur_type = it.field_type;
                    nbytes   = 0;
                    acc      = '0;
                    if (it.field_type == vdec_pkg::FT_BYTE ||
                        it.field_type == vdec_pkg::FT_RAW) begin
                        r.value         = {56'd0, it.data_byte};
                        r.result_type   = it.field_type;
                        r.last_of_field = 1'b1;
                        return 1'b1;
                    end
                    if (it.field_type <= vdec_pkg::FT_LONG) begin
                        acc    = {56'd0, it.data_byte};
                        nbytes = 1;
                        ph     = DEC_FIXED;
                        return 1'b0;
                    end
                    ph = (it.field_type == vdec_pkg::FT_STRING) ? DEC_LEN : DEC_VAR;
                    return leb_byte(it.data_byte, r);
                end
                DEC_FIXED: begin
                    need = (cur_type == vdec_pkg::FT_SHORT) ? 2 :
                           (cur_type == vdec_pkg::FT_INT)   ? 4 : 8;
                    acc  = {acc[55:0], it.data_byte};
                    nbytes++;
                    if (nbytes >= need) begin
                        r.value         = acc;
                        r.result_type   = cur_type;
                        r.last_of_field = 1'b1;
                        clear_field();
                        return 1'b1;
                    end
                    return 1'b0;
                end
                DEC_PAYLOAD: begin
                    str_left--;
                    r.value       = {56'd0, it.data_byte};
                    r.result_type = vdec_pkg::FT_STRING;
                    r.is_payload  = 1'b1;
                    if (str_left == 32'd0) begin
                        clear_field();
                        r.last_of_field = 1'b1;
                    end
                    return 1'b1;
                end
                default: return leb_byte(it.data_byte, r);
            endcase
        endfunction

        function void note_beat(vdec_pkg::item_t it);
            vdec_pkg::res_t r;
            if (decode_beat(it, r))
                expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(vdec_pkg::res_t got);
            vdec_pkg::res_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result: value %h status %0d",
                                 got.value, got.status));
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.value !== want.value)
                report($sformatf("result %0d: value %h, expected %h",
                                 n_checked, got.value, want.value));
            if (got.result_type !== want.result_type)
                report($sformatf("result %0d: type %0d, expected %0d",
                                 n_checked, got.result_type, want.result_type));
            if (got.status !== want.status)
                report($sformatf("result %0d: status %0d, expected %0d",
                                 n_checked, got.status, want.status));
            if (got.is_payload !== want.is_payload)
                report($sformatf("result %0d: is_payload %b, expected %b",
                                 n_checked, got.is_payload, want.is_payload));
            if (got.last_of_field !== want.last_of_field)
                report($sformatf("result %0d: tlast %b, expected %b",
                                 n_checked, got.last_of_field, want.last_of_field));
            if (got.bytes_consumed !== want.bytes_consumed)
                report($sformatf("result %0d: count %0d, expected %0d",
                                 n_checked, got.bytes_consumed, want.bytes_consumed));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] data_byte
    logic [3:0]  s_tuser   = '0;     // [0] kind, [3:1] field_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;            // [63:0] value, [95:64] bytes_consumed
    logic [5:0]  m_tuser;            // [2:0] result_type, [4:3] status, [5] is_payload
    logic        m_tlast;            // last_of_field
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [3:0]  cfg_data  = '0;

    field_scoreboard field_sb;

    // stimulus-side knobs
    bit         tx_burst      = 1'b0;   // no input gaps while set
    bit         hold_request  = 1'b0;   // asks the result side for one long stall
    int         beats_sent    = 0;
    logic [3:0] lim_vi        = vdec_pkg::VARINT_MAX_RST;
    logic [3:0] lim_vl        = vdec_pkg::VARLONG_MAX_RST;

    field_deserializer_varint u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one beat after a random gap and wait for the handshake. Valid stays
    // high into the next beat when that one has no gap.
    task automatic send_beat(logic kind, logic [2:0] ftype, logic [7:0] data);
        vdec_pkg::item_t it;
        int              gap;
        it.kind       = kind;
        it.field_type = ftype;
        it.data_byte  = data;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {ftype, kind};
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        field_sb.note_beat(it);
        beats_sent++;
    endtask

    // Field type goes with the first byte; later bytes carry random type bits,
    // which the decoder must ignore mid-field.
    task automatic send_bytes(logic [2:0] ftype, logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            send_beat(vdec_pkg::KIND_DATA, (i == 0) ? ftype : 3'($urandom), q[i]);
    endtask

    // up to 8 bytes, first byte in the low bits
    task automatic send_literal(logic [2:0] ftype, logic [63:0] raw, int n);
        logic [7:0] q[$];
        for (int i = 0; i < n; i++)
            q.push_back(raw[8*i +: 8]);
        send_bytes(ftype, q);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One field with random content, mostly well formed. Overlong varints and
    // fields cut short by end of buffer are mixed in.
    task automatic send_field(logic [2:0] ftype);
        logic [7:0]  q[$];
        logic [7:0]  b;
        logic [31:0] len;
        int          nb;
        int          lim;
        int          cut;
        int          n_pay;
        bit          over;
        bit          cut_short;
        cut_short = 1'b0;
        case (ftype)
            vdec_pkg::FT_SHORT, vdec_pkg::FT_INT, vdec_pkg::FT_LONG: begin
                nb = (ftype == vdec_pkg::FT_SHORT) ? 2 :
                     (ftype == vdec_pkg::FT_INT)   ? 4 : 8;
                for (int i = 0; i < nb; i++)
                    q.push_back(pick_byte());
            end
            vdec_pkg::FT_VARINT, vdec_pkg::FT_VARLONG: begin
                lim  = (ftype == vdec_pkg::FT_VARLONG) ? int'(lim_vl) : int'(lim_vi);
                over = (lim == 0) || ($urandom_range(0, 9) == 0);
                nb   = over ? lim + 1 : $urandom_range(1, lim);
                for (int i = 0; i < nb; i++) begin
                    b = pick_byte();
                    if (i < nb - 1)
                        b[7] = 1'b1;
                    else if (!over)
                        b[7] = 1'b0;
                    q.push_back(b);
                end
            end
            vdec_pkg::FT_STRING: begin
                case ($urandom_range(0, 9))
                    0, 1:    len = $urandom_range(7, 40);
                    2:       len = $urandom;
                    default: len = $urandom_range(0, 6);
                endcase
                do
                begin
                    b   = {1'b0, len[6:0]};
                    len = len >> 7;
                    if (len != 0)
                        b[7] = 1'b1;
                    q.push_back(b);
                end
                while (len != 0);
                if (q.size() > int'(lim_vi)) begin
                    // length too long for the limit: decoder stops at the extra byte
                    while (q.size() > int'(lim_vi) + 1)
                        void'(q.pop_back());
                end else begin
                    // recover the length to size the payload
                    len = '0;
                    for (int i = q.size() - 1; i >= 0; i--)
                        len = (len << 7) | 32'(q[i] & vdec_pkg::GROUP_MASK);
                    if (len <= 40) begin
                        n_pay = len;
                    end else begin
                        // huge length: a few payload bytes, then end of buffer
                        n_pay     = $urandom_range(0, 4);
                        cut_short = 1'b1;
                    end
                    for (int i = 0; i < n_pay; i++)
                        q.push_back(8'($urandom));
                end
            end
            default: q.push_back(pick_byte());
        endcase
        if (!cut_short && q.size() > 1 && $urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut)
                void'(q.pop_back());
            cut_short = 1'b1;
        end
        send_bytes(ftype, q);
        if (cut_short)
            send_beat(vdec_pkg::KIND_END, 3'($urandom), 8'($urandom));
    endtask

    task automatic run_random(int n_beats);
        int stop;
        stop = beats_sent + n_beats;
        while (beats_sent < stop) begin
            if ($urandom_range(0, 7) == 0)
                tx_burst = !tx_burst;
            case ($urandom_range(0, 19))
                0, 1:    send_beat(vdec_pkg::KIND_END, 3'($urandom), 8'($urandom));
                2, 3:    send_beat(1'($urandom), 3'($urandom), 8'($urandom));   // noise
                default: send_field(3'($urandom_range(0, 7)));
            endcase
        end
    endtask

    // End the buffer so the decoder is idle, then wait out every result.
    task automatic drain_decoder();
        send_beat(vdec_pkg::KIND_END, vdec_pkg::FT_BYTE, 8'h00);
        s_tvalid <= 1'b0;
        while (field_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both limits written back to back; only called with the decoder idle.
    task automatic program_limits(logic [3:0] vi, logic [3:0] vl);
        drain_decoder();
        cfg_we    <= 1'b1;
        cfg_index <= vdec_pkg::CFG_VARINT_MAX;
        cfg_data  <= vi;
        @(posedge clk);
        field_sb.set_limit(vdec_pkg::CFG_VARINT_MAX, vi);
        cfg_index <= vdec_pkg::CFG_VARLONG_MAX;
        cfg_data  <= vl;
        @(posedge clk);
        field_sb.set_limit(vdec_pkg::CFG_VARLONG_MAX, vl);
        cfg_we <= 1'b0;
        lim_vi = vi;
        lim_vl = vl;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        field_sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset limits (varint 5, varlong 10)
        send_beat(vdec_pkg::KIND_END, vdec_pkg::FT_BYTE, 8'h00);   // done, empty buffer
        send_literal(vdec_pkg::FT_BYTE, 64'hFF, 1);
        send_literal(vdec_pkg::FT_RAW, 64'h00, 1);                 // type seven
        send_literal(vdec_pkg::FT_SHORT, 64'h0180, 2);
        send_literal(vdec_pkg::FT_INT, 64'hFFFF_FFFF, 4);
        send_literal(vdec_pkg::FT_LONG, 64'hEFCD_AB89_6745_2301, 8);
        send_literal(vdec_pkg::FT_VARINT, 64'h7F_FFFF_FFFF, 5);    // top bits dropped
        send_literal(vdec_pkg::FT_VARLONG, 64'h00, 1);
        send_literal(vdec_pkg::FT_STRING, 64'h00, 1);              // empty string
        send_literal(vdec_pkg::FT_STRING, 64'h5A01, 2);            // one payload byte
        send_literal(vdec_pkg::FT_SHORT, 64'h12, 1);
        send_beat(vdec_pkg::KIND_END, vdec_pkg::FT_BYTE, 8'h00);   // truncated mid-field

        // limits of one byte each; overlong on the second byte
        program_limits(4'd1, 4'd1);
        send_literal(vdec_pkg::FT_VARINT, 64'h8080, 2);
        send_literal(vdec_pkg::FT_VARLONG, 64'h0180, 2);
        run_random(280);

        // widest legal limits, with one long stall on the result side
        program_limits(4'd10, 4'd10);
        hold_request = 1'b1;
        run_random(280);

        // zero rejects every first byte; 15 is the register maximum
        program_limits(4'd0, 4'd15);
        run_random(200);

        program_limits(4'd3, 4'd7);
        run_random(280);

        program_limits(4'($urandom_range(1, 10)), 4'($urandom_range(1, 10)));
        run_random(280);

        program_limits(vdec_pkg::VARINT_MAX_RST, vdec_pkg::VARLONG_MAX_RST);
        run_random(380);

        drain_decoder();
        if (field_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, bursts of full rate, one long hold
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        vdec_pkg::res_t got;
        int             stall;
        bit             rx_burst;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                // the input keeps offering beats meanwhile, so the decoder backs up
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.value          = m_tdata[63:0];
            got.bytes_consumed = m_tdata[95:64];
            got.result_type    = m_tuser[2:0];
            got.status         = m_tuser[4:3];
            got.is_payload     = m_tuser[5];
            got.last_of_field  = m_tlast;
            field_sb.check_result(got);
        end
    end

    // hang guard: stops the run far beyond the slowest correct run
    initial
    begin : watchdog
        #(4_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/vdec_pkg.sv
hw/rtl/vdec_core.sv
hw/rtl/field_deserializer_varint.sv
tb/tb_top.sv
